// ----- hw/rtl/fgss_pkg.sv -----
// Shared types and constants of the Fibonacci-gap shell sorter.
// No dependencies; compile first.
package fgss_pkg;

  localparam int DATA_W           = 32;
  localparam int MAX_ELEMENTS_DEF = 64;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FIB,
    ST_KEY_RD,
    ST_KEY_WAIT,
    ST_CMP,
    ST_PUT,
    ST_EMIT_RD,
    ST_EMIT_WAIT
  } fgss_state_t;

endpackage

// ----- hw/rtl/fgss_in_if.sv -----
// Input channel of the sorter: one element word per handshake.
// Depends on fgss_pkg.
interface fgss_in_if;
  import fgss_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;
  logic                     last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// ----- hw/rtl/fgss_out_if.sv -----
// Result channel of the sorter: one sorted word per handshake.
// Depends on fgss_pkg.
interface fgss_out_if;
  import fgss_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     end_of_set;
  logic                     dropped;

  modport source (output valid, output sorted_value, output end_of_set, output dropped,
                  input ready);
  modport sink   (input valid, input sorted_value, input end_of_set, input dropped,
                  output ready);
endinterface

// ----- hw/rtl/fgss_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fgss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/fibonacci_gap_shell_sorter_top.sv -----
// Fibonacci-gap shell sorter, top level. Depends on fgss_pkg, fgss_in_if, fgss_out_if, fgss_ram.
//
// The block collects signed 32-bit words into an internal RAM of MAX_ELEMENTS entries, one
// word per cycle, until a word marked last arrives (that word is kept too). Words that
// arrive once the RAM is full are discarded, and every result of that set then carries
// dropped = 1; a last word still closes the set when it is discarded. The set is then
// shell-sorted in place, ascending, with Fibonacci gaps: the largest Fibonacci number
// below the count first, then each earlier one down to 1. Each pass is a gapped insertion
// sort that holds the key in a register and shifts larger entries up by one gap. Then the
// sorted words leave on the result channel, end_of_set marking the final one, and the block
// goes back to loading. Finding the first gap climbs the Fibonacci sequence one term at a
// time until the next term would reach the count. Each insertion reads the key, waits for
// the RAM, then compares and shifts larger entries one at a time; a key that stops on a
// smaller entry is written in the compare state, one that lands at the bottom of its chain
// in a separate put state. A gap change, and closing the gap-1 pass, happen in the key-read
// state. Emission reads each result and then registers it, and waits while the result
// register is full and the sink is not ready. Everything is bound by the single RAM read
// port and its registered read. While the last result waits in the output register, the
// next set is already being loaded.
module fibonacci_gap_shell_sorter_top
  #(
  parameter int MAX_ELEMENTS = fgss_pkg::MAX_ELEMENTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  fgss_in_if.sink    in_word,
  fgss_out_if.source out_word
);
  import fgss_pkg::*;

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  // Control state
  fgss_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;       // words held in the current set
  logic          ovf_r, ovf_nxt;       // a word of this set was discarded
  logic          out_valid_r, out_valid_nxt;

  // Sort bookkeeping; i_r doubles as the emit index
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] loc_r, loc_nxt;
  logic [CW-1:0] gap_r, gap_nxt;
  logic [CW-1:0] before_r, before_nxt;
  logic [CW-1:0] x_r, x_nxt;
  logic [CW-1:0] y_r, y_nxt;
  logic signed [DATA_W-1:0] key_r, key_nxt;

  // Result register
  logic signed [DATA_W-1:0] out_value_r, out_value_nxt;
  logic                     out_end_r, out_end_nxt;
  logic                     out_drop_r, out_drop_nxt;

  // RAM port
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // Shared conditions
  logic          in_acc, out_acc, out_free;
  logic          room;
  logic [CW:0]   fib_sum;
  logic          fib_more;
  logic          pass_done;
  logic          greater;
  logic [CW-1:0] loc_gap, loc_gap2;
  logic          loc_gap_ge;
  logic [CW-1:0] i_inc;
  logic          emit_last;

  fgss_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_word.ready = (state_r == ST_LOAD);
  assign in_acc        = in_word.valid && in_word.ready;

  assign out_word.valid        = out_valid_r;
  assign out_word.sorted_value = out_value_r;
  assign out_word.end_of_set   = out_end_r;
  assign out_word.dropped      = out_drop_r;
  assign out_acc               = out_valid_r && out_word.ready;
  assign out_free              = !out_valid_r || out_word.ready;

  assign room       = (cnt_r < CW'(MAX_ELEMENTS));
  assign fib_sum    = {1'b0, x_r} + {1'b0, y_r};
  assign fib_more   = (fib_sum < {1'b0, cnt_r});
  assign pass_done  = (i_r >= cnt_r);
  assign greater    = ($signed(ram_rdata) > key_r);
  assign loc_gap    = loc_r - gap_r;
  assign loc_gap2   = loc_gap - gap_r;
  assign loc_gap_ge = (loc_gap >= gap_r);
  assign i_inc      = i_r + CW'(1);
  assign emit_last  = (i_inc == cnt_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc && in_word.last) begin
          state_nxt = ST_FIB;
        end
      end
      ST_FIB: begin
        if (!fib_more) begin
          state_nxt = (gap_r == '0) ? ST_EMIT_RD : ST_KEY_RD;
        end
      end
      ST_KEY_RD: begin
        if (!pass_done) begin
          state_nxt = ST_KEY_WAIT;
        end else if (gap_r == CW'(1)) begin
          state_nxt = ST_EMIT_RD;
        end
      end
      ST_KEY_WAIT: state_nxt = ST_CMP;
      ST_CMP: begin
        if (!greater) begin
          state_nxt = ST_KEY_RD;
        end else if (!loc_gap_ge) begin
          state_nxt = ST_PUT;
        end
      end
      ST_PUT: state_nxt = ST_KEY_RD;
      ST_EMIT_RD: begin
        if (out_free) begin
          state_nxt = ST_EMIT_WAIT;
        end
      end
      ST_EMIT_WAIT: state_nxt = emit_last ? ST_LOAD : ST_EMIT_RD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    loc_nxt       = loc_r;
    gap_nxt       = gap_r;
    before_nxt    = before_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    key_nxt       = key_r;
    out_value_nxt = out_value_r;
    out_end_nxt   = out_end_r;
    out_drop_nxt  = out_drop_r;
    out_valid_nxt = out_acc ? 1'b0 : out_valid_r;
    ram_we        = 1'b0;
    ram_waddr     = loc_r[AW-1:0];
    ram_wdata     = key_r;
    ram_raddr     = i_r[AW-1:0];

    case (state_r)
      ST_LOAD: begin
        // Store while there is room, else drop and flag
        if (in_acc) begin
          if (room) begin
            ram_we    = 1'b1;
            ram_waddr = cnt_r[AW-1:0];
            ram_wdata = in_word.value;
            cnt_nxt   = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          x_nxt      = '0;
          y_nxt      = CW'(1);
          gap_nxt    = '0;
          before_nxt = '0;
          i_nxt      = '0;
        end
      end
      ST_FIB: begin
        // Climb the Fibonacci sequence to the largest term below the count
        if (fib_more) begin
          x_nxt      = y_r;
          y_nxt      = fib_sum[CW-1:0];
          gap_nxt    = fib_sum[CW-1:0];
          before_nxt = y_r;
        end else begin
          i_nxt = (gap_r == '0) ? '0 : gap_r;
        end
      end
      ST_KEY_RD: begin
        if (!pass_done) begin
          ram_raddr = i_r[AW-1:0];
          loc_nxt   = i_r;
        end else if (gap_r == CW'(1)) begin
          i_nxt = '0;
        end else begin
          // Step the gap back one Fibonacci term
          gap_nxt    = before_r;
          before_nxt = gap_r - before_r;
          i_nxt      = before_r;
        end
      end
      ST_KEY_WAIT: begin
        key_nxt   = ram_rdata;
        ram_raddr = loc_gap[AW-1:0];
      end
      ST_CMP: begin
        if (greater) begin
          // Shift the larger entry up one gap, keep walking down
          ram_we    = 1'b1;
          ram_waddr = loc_r[AW-1:0];
          ram_wdata = ram_rdata;
          loc_nxt   = loc_gap;
          ram_raddr = loc_gap2[AW-1:0];
        end else begin
          ram_we = 1'b1;
          i_nxt  = i_inc;
        end
      end
      ST_PUT: begin
        ram_we = 1'b1;
        i_nxt  = i_inc;
      end
      ST_EMIT_RD: begin
        ram_raddr = i_r[AW-1:0];
      end
      ST_EMIT_WAIT: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = ram_rdata;
        out_end_nxt   = emit_last;
        out_drop_nxt  = ovf_r;
        if (emit_last) begin
          cnt_nxt = '0;
          ovf_nxt = 1'b0;
        end else begin
          i_nxt = i_inc;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    loc_r       <= loc_nxt;
    gap_r       <= gap_nxt;
    before_r    <= before_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    key_r       <= key_nxt;
    out_value_r <= out_value_nxt;
    out_end_r   <= out_end_nxt;
    out_drop_r  <= out_drop_nxt;
  end

endmodule
